@@ rtl/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

   localparam int MAX_FIELD_WIDTH = 32;
   localparam int VALUE_BITS      = 64;
   localparam int DEC_DIGITS      = 20;
   localparam int NIBBLE_COUNT    = VALUE_BITS / 4;
   localparam int BCD_BITS        = DEC_DIGITS * 4;
   localparam int STEP_BITS       = $clog2(VALUE_BITS);
   localparam int IDX_BITS        = $clog2(DEC_DIGITS);
   localparam int WIDTH_BITS      = 6;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ALPHA = 8'h41;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_PAD   = 6'b010000,
      ST_DIGIT = 6'b100000
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0000, d};
      end else begin
         c = CHAR_ALPHA + {4'b0000, d - 4'd10};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_ascii_formatter_unit.sv @@
// Integer to ASCII formatter.
// One request beat carries a 64-bit value, a radix select (signed decimal or
// upper-case hexadecimal), a 32/64-bit width flag, a minimum field width and
// a pad select. The block answers with one response beat per character, left
// to right, and tlast marks the final character of the number.
// A decimal value is converted by a shift-and-add-three loop, one bit per
// cycle. A scan then finds the leading digit, one digit per cycle, from the
// top of 20 digits in decimal or 16 in hexadecimal, where no conversion is
// needed. The characters then go out in order: the minus sign if any, the
// pad characters, then the digits.
// The block takes one item at a time; req_tready is high only between items.
// The response side has a single output register: when the receiver holds
// rsp_tready low the sequencer waits with the character in place and loses
// nothing. The next request is taken while the final character still waits.
// Reset is synchronous and empties the block: no response beat is pending
// and the block is ready for a request in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_unit
   import i2a_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Bits 63:0 number, 69:64 min_width, 70 pad_with_zero, 71 zero.
   input  wire logic [71:0] req_tdata,
   // Bit 0 hex_mode, bit 1 value_is_wide.
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Bits 7:0 out_char.
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   state_type               state_ff, state_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [WIDTH_BITS-1:0]   pad_cnt_ff, pad_cnt_in;
   logic [WIDTH_BITS-1:0]   width_ff, width_in;
   logic                    neg_ff, neg_in;
   logic                    hex_ff, hex_in;
   logic                    pad_zero_ff, pad_zero_in;
   logic                    out_valid_ff, out_valid_in;
   logic [7:0]              out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;

   logic [VALUE_BITS-1:0]   req_number;
   logic [WIDTH_BITS-1:0]   req_width;
   logic                    req_hex;
   logic                    req_wide;
   logic [VALUE_BITS-1:0]   ext_value;
   logic                    ext_neg;
   logic [VALUE_BITS-1:0]   magnitude;
   logic [BCD_BITS-1:0]     bcd_adj;
   logic [3:0]              cur_digit;
   logic [WIDTH_BITS-1:0]   num_digits;
   logic [WIDTH_BITS-1:0]   pad_needed;
   logic                    out_free;
   logic                    req_fire;

   assign req_number = req_tdata[VALUE_BITS-1:0];
   assign req_width  = req_tdata[VALUE_BITS +: WIDTH_BITS];
   assign req_hex    = req_tuser[0];
   assign req_wide   = req_tuser[1];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      if (req_wide) begin
         ext_value = req_number;
      end else if (req_hex) begin
         ext_value = {32'h0000_0000, req_number[31:0]};
      end else begin
         ext_value = {{32{req_number[31]}}, req_number[31:0]};
      end
      ext_neg   = !req_hex && ext_value[VALUE_BITS-1];
      magnitude = ext_neg ? (~ext_value + 64'd1) : ext_value;
   end

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign cur_digit  = bcd_ff[{idx_ff, 2'b00} +: 4];
   assign num_digits = WIDTH_BITS'(idx_ff) + 6'd1;
   assign pad_needed = (width_ff > num_digits) ? (width_ff - num_digits) : '0;

   always_comb begin
      state_in     = state_ff;
      bcd_in       = bcd_ff;
      bin_in       = bin_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      pad_cnt_in   = pad_cnt_ff;
      width_in     = width_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      pad_zero_in  = pad_zero_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in      = ext_neg;
               hex_in      = req_hex;
               pad_zero_in = req_tdata[VALUE_BITS + WIDTH_BITS];
               width_in    = (req_width > WIDTH_BITS'(MAX_FIELD_WIDTH))
                             ? WIDTH_BITS'(MAX_FIELD_WIDTH) : req_width;
               step_in     = '0;
               if (req_hex) begin
                  bcd_in   = {{(BCD_BITS-VALUE_BITS){1'b0}}, magnitude};
                  bin_in   = '0;
                  idx_in   = IDX_BITS'(NIBBLE_COUNT - 1);
                  state_in = ST_SCAN;
               end else begin
                  bcd_in   = '0;
                  bin_in   = magnitude;
                  idx_in   = IDX_BITS'(DEC_DIGITS - 1);
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in  = {bin_ff[VALUE_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(VALUE_BITS - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff != '0 && cur_digit == 4'd0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               pad_cnt_in = pad_needed;
               if (neg_ff) begin
                  state_in = ST_SIGN;
               end else if (pad_needed != '0) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = (pad_cnt_ff != '0) ? ST_PAD : ST_DIGIT;
            end
         end
         ST_PAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = pad_zero_ff ? CHAR_ZERO : CHAR_SPACE;
               out_last_in  = 1'b0;
               pad_cnt_in   = pad_cnt_ff - 1'b1;
               if (pad_cnt_ff == WIDTH_BITS'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char(cur_digit);
               out_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      bin_ff      <= bin_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      pad_cnt_ff  <= pad_cnt_in;
      width_ff    <= width_in;
      neg_ff      <= neg_in;
      hex_ff      <= hex_in;
      pad_zero_ff <= pad_zero_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // A taken request always starts either the decimal conversion or the scan.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_CONV || state_ff == ST_SCAN))
      else $error("request did not start conversion or scan");

   // A converted decimal digit must be a valid BCD digit.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIGIT || state_ff == ST_SCAN) && !hex_ff) |-> (cur_digit <= 4'd9))
      else $error("decimal digit out of range");

   // Hex digits never come from above the 64-bit value.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN || state_ff == ST_DIGIT) && hex_ff)
         |-> (idx_ff <= IDX_BITS'(NIBBLE_COUNT - 1)))
      else $error("hex digit index out of range");

   // The pad phase is entered only with characters left to pad.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> (pad_cnt_ff != '0))
      else $error("pad phase with empty pad count");

   // The final character of a number leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT && out_free && idx_ff == '0) |=> (req_tready && rsp_tlast))
      else $error("final character did not end the item");

endmodule

`default_nettype wire
